[sv/clt_pkg.sv]
// clt_pkg: types, command codes and keyword table of the command line tokenizer
// used by command_line_tokenizer; depends on nothing else
package clt_pkg;

   typedef enum logic [1:0] {
      MODE_BETWEEN = 2'd0,
      MODE_WORD    = 2'd1,
      MODE_NUMBER  = 2'd2,
      MODE_ZERO    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_EMPTY  = 2'd0,
      KIND_WORD   = 2'd1,
      KIND_NUMBER = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_PREV   = 3'd2,
      CMD_FIND   = 3'd3,
      CMD_DELETE = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   localparam int          NUM_KEYWORDS = 5;
   localparam logic [30:0] NUM_LIMIT    = 31'h7FFF_FFFF;
   localparam logic [7:0]  CHAR_SPACE   = 8'd32;
   localparam logic [7:0]  CHAR_LF      = 8'd10;
   localparam logic [7:0]  CHAR_ZERO    = 8'd48;
   localparam logic [7:0]  CHAR_NINE    = 8'd57;
   localparam logic [7:0]  CHAR_A_LOW   = 8'd97;
   localparam logic [7:0]  CHAR_Z_LOW   = 8'd122;

   // keyword k is command code k+1
   function automatic logic [2:0] kw_len(input logic [2:0] k);
      case (k)
         3'd0:    kw_len = 3'd6;   // insert
         3'd1:    kw_len = 3'd4;   // prev
         3'd2:    kw_len = 3'd4;   // find
         3'd3:    kw_len = 3'd6;   // delete
         3'd4:    kw_len = 3'd5;   // clear
         default: kw_len = 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] idx);
      logic [7:0] ch;
      ch = 8'd0;
      case (k)
         3'd0: begin
            case (idx)
               3'd0:    ch = "i";
               3'd1:    ch = "n";
               3'd2:    ch = "s";
               3'd3:    ch = "e";
               3'd4:    ch = "r";
               3'd5:    ch = "t";
               default: ch = 8'd0;
            endcase
         end
         3'd1: begin
            case (idx)
               3'd0:    ch = "p";
               3'd1:    ch = "r";
               3'd2:    ch = "e";
               3'd3:    ch = "v";
               default: ch = 8'd0;
            endcase
         end
         3'd2: begin
            case (idx)
               3'd0:    ch = "f";
               3'd1:    ch = "i";
               3'd2:    ch = "n";
               3'd3:    ch = "d";
               default: ch = 8'd0;
            endcase
         end
         3'd3: begin
            case (idx)
               3'd0:    ch = "d";
               3'd1:    ch = "e";
               3'd2:    ch = "l";
               3'd3:    ch = "e";
               3'd4:    ch = "t";
               3'd5:    ch = "e";
               default: ch = 8'd0;
            endcase
         end
         3'd4: begin
            case (idx)
               3'd0:    ch = "c";
               3'd1:    ch = "l";
               3'd2:    ch = "e";
               3'd3:    ch = "a";
               3'd4:    ch = "r";
               default: ch = 8'd0;
            endcase
         end
         default: ch = 8'd0;
      endcase
      kw_char = ch;
   endfunction

endpackage

[sv/command_line_tokenizer.sv]
// command_line_tokenizer: splits a command line into tokens and decodes one command
// per line; depends on clt_pkg
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | character, end_of_line
//   rsp     | out       | rsp_valid/rsp_stall  | command, word_start, word_length,
//           |           |                      | number_a, number_b, number_c
//
// one character is taken every cycle, unless a final character waits on a held result;
// a line's result passes from the input register, through scan and decode, into the
// result register once its final character is accepted
// reset (synchronous) clears the scan state and empties both registers
// rsp_stall holds the result; characters that do not end a line keep flowing,
// a final character waits in the input register until the result register frees
module command_line_tokenizer #(
   parameter int MAX_LINE = 131072
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_end_of_line,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_command,
   output logic [16:0] rsp_word_start,
   output logic [17:0] rsp_word_length,
   output logic [30:0] rsp_number_a,
   output logic [30:0] rsp_number_b,
   output logic [30:0] rsp_number_c
);

   localparam int PW = $clog2(MAX_LINE + 1);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_eol_ff;
   logic       in_load;
   logic       s1_go, s1_fire;

   // scan state
   clt_pkg::mode_type mode_ff, mode_in, sc_mode;
   logic [2:0]        count_ff, count_in, sc_count;
   logic              bad_ff, bad_in, sc_bad;
   logic [PW-1:0]     pos_ff, pos_in, sc_pos;
   logic [4:0]        match_ff, match_in, sc_match;
   logic [2:0]        ftl_ff, ftl_in, sc_ftl;
   clt_pkg::kind_type kinds_ff [4];
   clt_pkg::kind_type kinds_in [4];
   clt_pkg::kind_type sc_kinds [4];
   logic [PW-1:0]     ws_ff, ws_in, sc_ws;
   logic [PW-1:0]     wl_ff, wl_in, sc_wl;
   logic [30:0]       acc_ff [3];
   logic [30:0]       acc_in [3];
   logic [30:0]       sc_acc [3];
   logic [2:0]        ovf_ff, ovf_in, sc_ovf;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   clt_pkg::cmd_type  cmd_ff, cmd_in;
   logic [16:0]       start_ff, start_in;
   logic [17:0]       length_ff, length_in;
   logic [30:0]       na_ff, na_in, nb_ff, nb_in, nc_ff, nc_in;

   // character classes
   logic is_sep, is_lower, is_digit, is_zero;
   logic [30:0] acc_sel;
   logic        ovf_sel;
   logic [34:0] dig_acc;
   logic        dig_big;
   logic [4:0]  kw_next;
   logic [2:0]  ftl_next;
   logic [31:0] ws_wide, wl_wide;
   logic [2:0]  kw_code;

   assign s1_go     = !in_eol_ff || !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = in_valid_ff && s1_go;
   assign req_stall = in_valid_ff && !s1_go;
   assign in_load   = req_valid && !req_stall;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   assign is_sep   = (in_char_ff == clt_pkg::CHAR_SPACE) || (in_char_ff == clt_pkg::CHAR_LF);
   assign is_lower = (in_char_ff >= clt_pkg::CHAR_A_LOW) && (in_char_ff <= clt_pkg::CHAR_Z_LOW);
   assign is_digit = (in_char_ff >= clt_pkg::CHAR_ZERO) && (in_char_ff <= clt_pkg::CHAR_NINE);
   assign is_zero  = (in_char_ff == clt_pkg::CHAR_ZERO);

   // accumulator of the current numeric argument
   always_comb begin
      case (count_ff)
         3'd1: begin
            acc_sel = acc_ff[0];
            ovf_sel = ovf_ff[0];
         end
         3'd2: begin
            acc_sel = acc_ff[1];
            ovf_sel = ovf_ff[1];
         end
         3'd3: begin
            acc_sel = acc_ff[2];
            ovf_sel = ovf_ff[2];
         end
         default: begin
            acc_sel = '0;
            ovf_sel = 1'b1;
         end
      endcase
   end

   // times ten as two shifts
   assign dig_acc = (35'(acc_sel) << 3) + (35'(acc_sel) << 1)
                    + 35'(in_char_ff - clt_pkg::CHAR_ZERO);
   assign dig_big = dig_acc > 35'(clt_pkg::NUM_LIMIT);

   always_comb begin
      kw_next = match_ff;
      for (int k = 0; k < clt_pkg::NUM_KEYWORDS; k++) begin
         if (ftl_ff >= clt_pkg::kw_len(3'(k)) || clt_pkg::kw_char(3'(k), ftl_ff) != in_char_ff)
            kw_next[k] = 1'b0;
      end
      ftl_next = (ftl_ff < 3'd7) ? ftl_ff + 3'd1 : ftl_ff;
   end

   // scan one character, then close an open token at end of line
   always_comb begin
      logic feed_kw, feed_dig, do_close;
      logic [PW-1:0] end_pos;
      sc_mode  = mode_ff;
      sc_count = count_ff;
      sc_bad   = bad_ff;
      sc_pos   = pos_ff;
      sc_match = match_ff;
      sc_ftl   = ftl_ff;
      sc_ws    = ws_ff;
      sc_wl    = wl_ff;
      sc_ovf   = ovf_ff;
      for (int i = 0; i < 4; i++) sc_kinds[i] = kinds_ff[i];
      for (int j = 0; j < 3; j++) sc_acc[j] = acc_ff[j];
      feed_kw  = 1'b0;
      feed_dig = 1'b0;
      do_close = 1'b0;
      end_pos  = pos_ff;

      if (pos_ff < PW'(MAX_LINE)) begin
         if (!bad_ff) begin
            case (mode_ff)
               clt_pkg::MODE_BETWEEN: begin
                  if (!is_sep) begin
                     if (count_ff >= 3'd4) begin
                        sc_bad = 1'b1;
                     end else if (is_lower) begin
                        sc_kinds[count_ff[1:0]] = clt_pkg::KIND_WORD;
                        if (count_ff == 3'd1) sc_ws = pos_ff;
                        feed_kw = (count_ff == 3'd0);
                        sc_mode = clt_pkg::MODE_WORD;
                     end else if (is_zero) begin
                        sc_kinds[count_ff[1:0]] = clt_pkg::KIND_NUMBER;
                        sc_mode = clt_pkg::MODE_ZERO;
                     end else if (is_digit) begin
                        sc_kinds[count_ff[1:0]] = clt_pkg::KIND_NUMBER;
                        feed_dig = 1'b1;
                        sc_mode = clt_pkg::MODE_NUMBER;
                     end else begin
                        sc_bad = 1'b1;
                     end
                  end
               end
               clt_pkg::MODE_WORD: begin
                  if (is_lower) feed_kw = (count_ff == 3'd0);
                  else if (is_sep) do_close = 1'b1;
                  else sc_bad = 1'b1;
               end
               clt_pkg::MODE_NUMBER: begin
                  if (is_digit) feed_dig = 1'b1;
                  else if (is_sep) do_close = 1'b1;
                  else sc_bad = 1'b1;
               end
               default: begin
                  if (is_sep) do_close = 1'b1;
                  else sc_bad = 1'b1;
               end
            endcase
         end
         sc_pos = pos_ff + PW'(1);
      end

      if (feed_kw) begin
         sc_match = kw_next;
         sc_ftl   = ftl_next;
      end

      if (feed_dig && !ovf_sel) begin
         for (int j = 0; j < 3; j++) begin
            if (count_ff == 3'(j + 1)) begin
               sc_ovf[j] = dig_big;
               sc_acc[j] = dig_big ? 31'd0 : dig_acc[30:0];
            end
         end
      end

      // token still open when the line ends
      if (!do_close && in_eol_ff && !sc_bad && sc_mode != clt_pkg::MODE_BETWEEN) begin
         do_close = 1'b1;
         end_pos  = sc_pos;
      end

      if (do_close) begin
         if (sc_mode == clt_pkg::MODE_WORD && sc_count == 3'd1) sc_wl = end_pos - sc_ws;
         sc_count = sc_count + 3'd1;
         sc_mode  = clt_pkg::MODE_BETWEEN;
      end
   end

   // decode the command from the closed line
   always_comb begin
      kw_code   = 3'd0;
      cmd_in    = clt_pkg::CMD_NONE;
      start_in  = '0;
      length_in = '0;
      na_in     = '0;
      nb_in     = '0;
      nc_in     = '0;
      ws_wide   = 32'(sc_ws);
      wl_wide   = 32'(sc_wl);
      for (int k = 0; k < clt_pkg::NUM_KEYWORDS; k++) begin
         if (sc_match[k] && sc_ftl == clt_pkg::kw_len(3'(k))) kw_code = 3'(k + 1);
      end
      if (!sc_bad && sc_kinds[0] == clt_pkg::KIND_WORD) begin
         case (clt_pkg::cmd_type'(kw_code))
            clt_pkg::CMD_INSERT, clt_pkg::CMD_FIND: begin
               if (sc_kinds[1] == clt_pkg::KIND_WORD && sc_kinds[2] == clt_pkg::KIND_EMPTY &&
                   sc_kinds[3] == clt_pkg::KIND_EMPTY) begin
                  cmd_in    = clt_pkg::cmd_type'(kw_code);
                  start_in  = ws_wide[16:0];
                  length_in = wl_wide[17:0];
               end
            end
            clt_pkg::CMD_PREV: begin
               if (sc_kinds[1] == clt_pkg::KIND_NUMBER && sc_kinds[2] == clt_pkg::KIND_NUMBER &&
                   sc_kinds[3] == clt_pkg::KIND_NUMBER && sc_ovf == 3'b000) begin
                  cmd_in = clt_pkg::CMD_PREV;
                  na_in  = sc_acc[0];
                  nb_in  = sc_acc[1];
                  nc_in  = sc_acc[2];
               end
            end
            clt_pkg::CMD_DELETE: begin
               if (sc_kinds[1] == clt_pkg::KIND_NUMBER && sc_kinds[2] == clt_pkg::KIND_EMPTY &&
                   sc_kinds[3] == clt_pkg::KIND_EMPTY && !sc_ovf[0]) begin
                  cmd_in = clt_pkg::CMD_DELETE;
                  na_in  = sc_acc[0];
               end
            end
            clt_pkg::CMD_CLEAR: begin
               if (sc_kinds[1] == clt_pkg::KIND_EMPTY && sc_kinds[2] == clt_pkg::KIND_EMPTY &&
                   sc_kinds[3] == clt_pkg::KIND_EMPTY)
                  cmd_in = clt_pkg::CMD_CLEAR;
            end
            default: cmd_in = clt_pkg::CMD_NONE;
         endcase
      end
   end

   // next scan state: back to reset values after a line
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      bad_in   = bad_ff;
      pos_in   = pos_ff;
      match_in = match_ff;
      ftl_in   = ftl_ff;
      ws_in    = ws_ff;
      wl_in    = wl_ff;
      ovf_in   = ovf_ff;
      for (int i = 0; i < 4; i++) kinds_in[i] = kinds_ff[i];
      for (int j = 0; j < 3; j++) acc_in[j] = acc_ff[j];
      if (s1_fire) begin
         if (in_eol_ff) begin
            mode_in  = clt_pkg::MODE_BETWEEN;
            count_in = '0;
            bad_in   = 1'b0;
            pos_in   = '0;
            match_in = '1;
            ftl_in   = '0;
            ws_in    = '0;
            wl_in    = '0;
            ovf_in   = '0;
            for (int i = 0; i < 4; i++) kinds_in[i] = clt_pkg::KIND_EMPTY;
            for (int j = 0; j < 3; j++) acc_in[j] = '0;
         end else begin
            mode_in  = sc_mode;
            count_in = sc_count;
            bad_in   = sc_bad;
            pos_in   = sc_pos;
            match_in = sc_match;
            ftl_in   = sc_ftl;
            ws_in    = sc_ws;
            wl_in    = sc_wl;
            ovf_in   = sc_ovf;
            for (int i = 0; i < 4; i++) kinds_in[i] = sc_kinds[i];
            for (int j = 0; j < 3; j++) acc_in[j] = sc_acc[j];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_fire && in_eol_ff) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= clt_pkg::MODE_BETWEEN;
         count_ff     <= '0;
         bad_ff       <= 1'b0;
         pos_ff       <= '0;
         match_ff     <= '1;
         ftl_ff       <= '0;
         ws_ff        <= '0;
         wl_ff        <= '0;
         ovf_ff       <= '0;
         for (int i = 0; i < 4; i++) kinds_ff[i] <= clt_pkg::KIND_EMPTY;
         for (int j = 0; j < 3; j++) acc_ff[j] <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         bad_ff       <= bad_in;
         pos_ff       <= pos_in;
         match_ff     <= match_in;
         ftl_ff       <= ftl_in;
         ws_ff        <= ws_in;
         wl_ff        <= wl_in;
         ovf_ff       <= ovf_in;
         for (int i = 0; i < 4; i++) kinds_ff[i] <= kinds_in[i];
         for (int j = 0; j < 3; j++) acc_ff[j] <= acc_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_char_ff <= req_character;
         in_eol_ff  <= req_end_of_line;
      end
      if (s1_fire && in_eol_ff) begin
         cmd_ff    <= cmd_in;
         start_ff  <= start_in;
         length_ff <= length_in;
         na_ff     <= na_in;
         nb_ff     <= nb_in;
         nc_ff     <= nc_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = cmd_ff;
   assign rsp_word_start  = start_ff;
   assign rsp_word_length = length_ff;
   assign rsp_number_a    = na_ff;
   assign rsp_number_b    = nb_ff;
   assign rsp_number_c    = nc_ff;

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      s1_fire && in_eol_ff |=> count_ff == 3'd0 && mode_ff == clt_pkg::MODE_BETWEEN
                               && pos_ff == '0)
      else $error("scan state not cleared after end of line");

   a_line_end_result: assert property (@(posedge clock) disable iff (reset)
      s1_fire && in_eol_ff |=> rsp_valid_ff)
      else $error("end of line gave no result");

   a_token_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("more than four tokens counted");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      ovf_ff[0] |-> acc_ff[0] == 31'd0)
      else $error("overflowed number kept a value");

endmodule

[sim/tb_command_line_tokenizer.sv]
// tb_command_line_tokenizer: drives command lines into command_line_tokenizer one character
// per word, predicts each line's command and arguments, and checks every result
// depends on clt_pkg and command_line_tokenizer
module tb_command_line_tokenizer;

   localparam int LINE_LIMIT = 131072;
   localparam int IDLE_LIMIT = 500;

   typedef struct packed {
      logic [7:0] character;
      logic       eol;
      logic [3:0] gap;
   } char_item_type;

   typedef struct packed {
      clt_pkg::cmd_type command;
      logic [16:0]      word_start;
      logic [17:0]      word_length;
      logic [30:0]      number_a;
      logic [30:0]      number_b;
      logic [30:0]      number_c;
   } line_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character = 8'd0;
   logic        req_end_of_line = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_command;
   logic [16:0] rsp_word_start;
   logic [17:0] rsp_word_length;
   logic [30:0] rsp_number_a;
   logic [30:0] rsp_number_b;
   logic [30:0] rsp_number_c;

   command_line_tokenizer #(.MAX_LINE(LINE_LIMIT)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_character   (req_character),
      .req_end_of_line (req_end_of_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_command     (rsp_command),
      .rsp_word_start  (rsp_word_start),
      .rsp_word_length (rsp_word_length),
      .rsp_number_a    (rsp_number_a),
      .rsp_number_b    (rsp_number_b),
      .rsp_number_c    (rsp_number_c)
   );

   always #6 clock = ~clock;

   // keyword index k decodes to kw_cmd[k]
   string            kw_text [5] = '{"insert", "prev", "find", "delete", "clear"};
   clt_pkg::cmd_type kw_cmd  [5] = '{clt_pkg::CMD_INSERT, clt_pkg::CMD_PREV, clt_pkg::CMD_FIND,
                                     clt_pkg::CMD_DELETE, clt_pkg::CMD_CLEAR};

   // line scanner state, mirrored from the block's behavior
   clt_pkg::mode_type scan_mode;
   logic [2:0]        tok_count;
   logic              line_bad;
   int unsigned       line_pos;
   logic [4:0]        kw_live;
   logic [2:0]        kw_chars;
   clt_pkg::kind_type tok_kind [4];
   logic [16:0]       word_pos;
   logic [17:0]       word_size;
   longint unsigned   num_acc [3];
   logic [2:0]        num_ovf;

   char_item_type   pending_chars [$];
   line_result_type expected_lines [$];
   logic [7:0]      line_bytes [$];
   int              stim_count = 0;
   int              taken_chars = 0;
   int              error_count = 0;
   int              idle_cycles = 0;
   int              gap_left = 0;
   int              stall_left = 0;
   bit              rsp_quiet = 1'b0;
   logic            req_took = 1'b0;
   logic            rsp_took = 1'b0;

   task automatic clear_line_state();
      int i;
      scan_mode = clt_pkg::MODE_BETWEEN;
      tok_count = 3'd0;
      line_bad  = 1'b0;
      line_pos  = 0;
      kw_live   = 5'b11111;
      kw_chars  = 3'd0;
      word_pos  = '0;
      word_size = '0;
      num_ovf   = '0;
      for (i = 0; i < 4; i++) tok_kind[i] = clt_pkg::KIND_EMPTY;
      for (i = 0; i < 3; i++) num_acc[i] = 0;
   endtask

   task automatic match_keyword(input logic [7:0] ch);
      int k;
      for (k = 0; k < 5; k++) begin
         if (kw_chars >= kw_text[k].len() || kw_text[k][kw_chars] != ch) kw_live[k] = 1'b0;
      end
      if (kw_chars < 3'd7) kw_chars++;
   endtask

   task automatic add_digit(input logic [7:0] ch);
      int slot;
      if (tok_count < 3'd1 || tok_count > 3'd3) return;
      slot = tok_count - 1;
      if (num_ovf[slot]) return;
      num_acc[slot] = num_acc[slot] * 10 + (ch - clt_pkg::CHAR_ZERO);
      // overflow sticks and the value is dropped
      if (num_acc[slot] > 64'd2147483647) begin
         num_ovf[slot] = 1'b1;
         num_acc[slot] = 0;
      end
   endtask

   task automatic end_token(input int unsigned end_pos);
      if (scan_mode == clt_pkg::MODE_WORD && tok_count == 3'd1)
         word_size = 18'(end_pos - word_pos);
      tok_count++;
      scan_mode = clt_pkg::MODE_BETWEEN;
   endtask

   task automatic scan_byte(input logic [7:0] ch);
      bit sep, lower, digit;
      sep   = (ch == clt_pkg::CHAR_SPACE || ch == clt_pkg::CHAR_LF);
      lower = (ch >= clt_pkg::CHAR_A_LOW && ch <= clt_pkg::CHAR_Z_LOW);
      digit = (ch >= clt_pkg::CHAR_ZERO && ch <= clt_pkg::CHAR_NINE);
      case (scan_mode)
         clt_pkg::MODE_BETWEEN: begin
            if (sep) begin
            end else if (tok_count >= 3'd4) begin
               line_bad = 1'b1;
            end else if (lower) begin
               tok_kind[tok_count] = clt_pkg::KIND_WORD;
               if (tok_count == 3'd1) word_pos = line_pos[16:0];
               if (tok_count == 3'd0) match_keyword(ch);
               scan_mode = clt_pkg::MODE_WORD;
            end else if (ch == clt_pkg::CHAR_ZERO) begin
               tok_kind[tok_count] = clt_pkg::KIND_NUMBER;
               scan_mode = clt_pkg::MODE_ZERO;
            end else if (digit) begin
               tok_kind[tok_count] = clt_pkg::KIND_NUMBER;
               add_digit(ch);
               scan_mode = clt_pkg::MODE_NUMBER;
            end else begin
               line_bad = 1'b1;
            end
         end
         clt_pkg::MODE_WORD: begin
            if (lower) begin
               if (tok_count == 3'd0) match_keyword(ch);
            end else if (sep) begin
               end_token(line_pos);
            end else begin
               line_bad = 1'b1;
            end
         end
         clt_pkg::MODE_NUMBER: begin
            if (digit) add_digit(ch);
            else if (sep) end_token(line_pos);
            else line_bad = 1'b1;
         end
         default: begin
            // a leading zero may only be followed by a separator
            if (sep) end_token(line_pos);
            else line_bad = 1'b1;
         end
      endcase
   endtask

   function automatic line_result_type decode_line();
      line_result_type  r;
      clt_pkg::cmd_type cmd;
      int               k;
      r = '0;
      cmd = clt_pkg::CMD_NONE;
      if (line_bad || tok_kind[0] != clt_pkg::KIND_WORD) return r;
      for (k = 0; k < 5; k++) begin
         if (kw_live[k] && kw_chars == kw_text[k].len()) cmd = kw_cmd[k];
      end
      case (cmd)
         clt_pkg::CMD_INSERT, clt_pkg::CMD_FIND: begin
            if (tok_kind[1] == clt_pkg::KIND_WORD && tok_kind[2] == clt_pkg::KIND_EMPTY &&
                tok_kind[3] == clt_pkg::KIND_EMPTY) begin
               r.command     = cmd;
               r.word_start  = word_pos;
               r.word_length = word_size;
            end
         end
         clt_pkg::CMD_PREV: begin
            if (tok_kind[1] == clt_pkg::KIND_NUMBER && tok_kind[2] == clt_pkg::KIND_NUMBER &&
                tok_kind[3] == clt_pkg::KIND_NUMBER && num_ovf == 3'b000) begin
               r.command  = cmd;
               r.number_a = num_acc[0][30:0];
               r.number_b = num_acc[1][30:0];
               r.number_c = num_acc[2][30:0];
            end
         end
         clt_pkg::CMD_DELETE: begin
            if (tok_kind[1] == clt_pkg::KIND_NUMBER && tok_kind[2] == clt_pkg::KIND_EMPTY &&
                tok_kind[3] == clt_pkg::KIND_EMPTY && !num_ovf[0]) begin
               r.command  = cmd;
               r.number_a = num_acc[0][30:0];
            end
         end
         clt_pkg::CMD_CLEAR: begin
            if (tok_kind[1] == clt_pkg::KIND_EMPTY && tok_kind[2] == clt_pkg::KIND_EMPTY &&
                tok_kind[3] == clt_pkg::KIND_EMPTY) r.command = cmd;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic take_char(input logic [7:0] ch, input logic eol);
      // characters past the line limit are not scanned and do not advance the position
      if (line_pos < LINE_LIMIT) begin
         if (!line_bad) scan_byte(ch);
         line_pos++;
      end
      if (eol) begin
         if (!line_bad && scan_mode != clt_pkg::MODE_BETWEEN) end_token(line_pos);
         expected_lines.push_back(decode_line());
         clear_line_state();
      end
   endtask

   task automatic check_field(input string name, input logic [30:0] want,
                              input logic [30:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result();
      line_result_type want;
      if (expected_lines.size() == 0) begin
         $display("%0t: result with no line pending, command %0d", $time, rsp_command);
         error_count++;
      end else begin
         want = expected_lines.pop_front();
         check_field("command", 31'(want.command), 31'(rsp_command));
         check_field("word_start", 31'(want.word_start), 31'(rsp_word_start));
         check_field("word_length", 31'(want.word_length), 31'(rsp_word_length));
         check_field("number_a", want.number_a, rsp_number_a);
         check_field("number_b", want.number_b, rsp_number_b);
         check_field("number_c", want.number_c, rsp_number_c);
      end
   endtask

   // line building
   task automatic add_text(input string t);
      int i;
      for (i = 0; i < t.len(); i++) line_bytes.push_back(t[i]);
   endtask

   task automatic add_seps(input int lo, input int hi);
      int n;
      n = $urandom_range(lo, hi);
      repeat (n) line_bytes.push_back(($urandom_range(0, 3) == 0) ? clt_pkg::CHAR_LF
                                                                   : clt_pkg::CHAR_SPACE);
   endtask

   task automatic add_word(input int lo, input int hi);
      int n;
      n = $urandom_range(lo, hi);
      repeat (n) line_bytes.push_back(clt_pkg::CHAR_A_LOW + 8'($urandom_range(0, 25)));
   endtask

   function automatic string number_text();
      case ($urandom_range(0, 9))
         0, 1:    return $sformatf("%0d", $urandom_range(0, 9));
         2, 3:    return $sformatf("%0d", $urandom_range(10, 99999));
         4, 5:    return $sformatf("%0d", $urandom & 32'h7FFF_FFFF);
         6:       return $sformatf("%0d", 64'd2147483640 + $urandom_range(0, 15));
         7:       return $sformatf("%0d%0d", $urandom_range(1, 99), $urandom);
         8:       return {"0", $sformatf("%0d", $urandom_range(0, 999))};
         default: return "0";
      endcase
   endfunction

   task automatic add_command(input int k);
      add_text(kw_text[k]);
      case (kw_cmd[k])
         clt_pkg::CMD_INSERT, clt_pkg::CMD_FIND: begin
            add_seps(1, 3);
            add_word(1, 12);
         end
         clt_pkg::CMD_PREV: begin
            repeat (3) begin
               add_seps(1, 3);
               add_text(number_text());
            end
         end
         clt_pkg::CMD_DELETE: begin
            add_seps(1, 3);
            add_text(number_text());
         end
         default: begin
         end
      endcase
   endtask

   task automatic finish_line(input bit calm);
      char_item_type it;
      int            i;
      if (line_bytes.size() == 0) line_bytes.push_back(clt_pkg::CHAR_A_LOW);
      for (i = 0; i < line_bytes.size(); i++) begin
         it.character = line_bytes[i];
         it.eol       = (i == line_bytes.size() - 1);
         it.gap       = calm ? 4'd0 : 4'($urandom_range(0, 10));
         pending_chars.push_back(it);
      end
      stim_count += line_bytes.size();
      line_bytes.delete();
   endtask

   // sender: new word at the falling edge once the last one was taken
   always @(negedge clock) begin
      char_item_type next_char;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // stalled, hold the word
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (pending_chars.size() != 0) begin
         next_char = pending_chars.pop_front();
         req_character   <= next_char.character;
         req_end_of_line <= next_char.eol;
         req_valid       <= 1'b1;
         if (pending_chars.size() != 0) gap_left = pending_chars[0].gap;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: stall drawn after every accepted result, with quiet stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(0, 7) == 0) rsp_quiet = !rsp_quiet;
            stall_left = rsp_quiet ? 0 : $urandom_range(0, 10);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
         rsp_took <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_took <= req_valid && !req_stall;
         rsp_took <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall) begin
            take_char(req_character, req_end_of_line);
            taken_chars++;
         end
         if (rsp_valid && !rsp_stall) check_result();
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      int sel;
      int idx;
      bit calm;
      clear_line_state();

      add_text("insert abc");              finish_line(0);
      add_text("find z");                  finish_line(0);
      add_text("delete 0");                finish_line(0);
      add_text("delete 2147483647");       finish_line(0);
      add_text("delete 2147483648");       finish_line(0);
      add_text("prev 0 1 2147483647");     finish_line(0);
      add_text("prev 1 99999999999 3");    finish_line(0);
      add_text("clear\n");                 finish_line(0);
      add_text("  insert\nxyz  ");         finish_line(0);
      add_text("delete 01");               finish_line(0);
      add_text("delete 1a");               finish_line(0);
      add_text("find ab1");                finish_line(0);
      add_text("insert a b");              finish_line(0);
      add_text("prev 1 2 3 4");            finish_line(0);
      add_text("clear a");                 finish_line(0);
      add_text("inser abc");               finish_line(0);
      add_text("inserts abc");             finish_line(0);
      add_text("find A");                  finish_line(0);
      add_text("7 insert");                finish_line(0);
      add_text(" ");                       finish_line(0);
      add_text("clear ");
      line_bytes.push_back(8'd0);          finish_line(0);
      add_text("find ");
      line_bytes.push_back(8'd255);        finish_line(1);

      while (stim_count < 1400) begin
         sel  = $urandom_range(0, 15);
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) == 0) add_seps(1, 3);
         case (sel)
            0, 1, 2, 3, 4, 5, 6: add_command($urandom_range(0, 4));
            7: begin
               // random argument pattern for the keyword, often the wrong one
               add_text(kw_text[$urandom_range(0, 4)]);
               repeat ($urandom_range(1, 3)) begin
                  add_seps(1, 2);
                  if ($urandom_range(0, 1)) add_word(1, 6);
                  else add_text(number_text());
               end
            end
            8: begin
               // one to four extra words after a command
               add_command($urandom_range(0, 4));
               repeat ($urandom_range(1, 4)) begin
                  add_seps(1, 2);
                  add_word(1, 4);
               end
            end
            9: begin
               // near-miss keywords
               idx = $urandom_range(0, 4);
               case ($urandom_range(0, 2))
                  0: add_text(kw_text[idx].substr(0, kw_text[idx].len() - 2));
                  1: add_text({kw_text[idx], "s"});
                  default: add_word(1, 7);
               endcase
               if ($urandom_range(0, 1)) begin
                  add_seps(1, 2);
                  add_word(1, 5);
               end
            end
            10: begin
               repeat ($urandom_range(1, 16)) begin
                  if ($urandom_range(0, 3) == 0) line_bytes.push_back(clt_pkg::CHAR_SPACE);
                  else line_bytes.push_back(8'($urandom_range(0, 255)));
               end
            end
            11: begin
               add_text(number_text());
               add_seps(1, 2);
               add_command($urandom_range(0, 4));
            end
            default: begin
               add_command($urandom_range(0, 4));
               idx = $urandom_range(0, line_bytes.size() - 1);
               if ($urandom_range(0, 1)) line_bytes[idx] = 8'($urandom_range(0, 255));
               else line_bytes[idx] = clt_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
            end
         endcase
         // end of line on a separator or inside an open token
         if ($urandom_range(0, 1)) add_seps(1, 2);
         finish_line(calm);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (taken_chars != stim_count) @(posedge clock);
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_lines.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
